// ===== hw/rtl/mic_pkg.sv =====
package mic_pkg;

  localparam int MAX_LEN_DEF = 8;
  localparam int FIFO_DEPTH  = 2;

  localparam int IDX_W  = 19;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 4;
  localparam int DIG_W  = 3;
  // 4 * 5^(IDX_DIGITS-1) must fit
  localparam int THR_W  = 21;
  // longest motif length the decoder searches; only motifs up to 8 long fit wholly in IDX_W bits
  localparam int IDX_DIGITS = 9;

  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T = 8'h54;
  localparam logic [CHAR_W-1:0] CH_N = 8'h4E;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } mic_cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_RANGE    = 2'd2
  } mic_status_t;

  typedef enum logic {
    KIND_SINGLE = 1'b0,   // one result carrying value as index_out
    KIND_DIGITS = 1'b1    // len results, one character each
  } mic_kind_t;

  typedef struct packed {
    mic_kind_t          kind;
    logic [IDX_W-1:0]   value;   // encode index, or decode remainder
    logic [LEN_W-1:0]   len;
    mic_status_t        status;
  } mic_entry_t;

  function automatic logic [DIG_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIG_W-1:0] d;
    unique case (c)
      CH_C:    d = 3'd1;
      CH_G:    d = 3'd2;
      CH_T:    d = 3'd3;
      CH_N:    d = 3'd4;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      3'd1:    c = CH_C;
      3'd2:    c = CH_G;
      3'd3:    c = CH_T;
      3'd4:    c = CH_N;
      default: c = CH_A;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] pow5(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd5;
    end
    return p;
  endfunction

  // count of all motifs shorter than l
  function automatic logic [63:0] cum_off(input int l);
    logic [63:0] s;
    s = 64'd0;
    for (int i = 1; i < l; i++) begin
      s = s + pow5(i);
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/mic_if.sv =====
interface mic_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [mic_pkg::CHAR_W-1:0]    char_in;
  logic                          char_is_last;
  logic [mic_pkg::IDX_W-1:0]     index_in;

  modport source(output valid, command, char_in, char_is_last, index_in, input ready);
  modport sink(input valid, command, char_in, char_is_last, index_in, output ready);
endinterface

interface mic_out_if;
  logic                          valid;
  logic                          ready;
  logic [mic_pkg::IDX_W-1:0]     index_out;
  logic [mic_pkg::CHAR_W-1:0]    char_out;
  logic [mic_pkg::LEN_W-1:0]     motif_length;
  logic                          run_last;
  logic [1:0]                    status;

  modport source(output valid, index_out, char_out, motif_length, run_last, status,
                 input ready);
  modport sink(input valid, index_out, char_out, motif_length, run_last, status,
               output ready);
endinterface

// ===== hw/rtl/mic_front.sv =====
module mic_front #(
  parameter int MAX_LEN = mic_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  mic_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                q_push,
  output mic_pkg::mic_entry_t q_entry
);

  localparam int CW      = $clog2(MAX_LEN + 1);
  localparam int DEC_MAX = (MAX_LEN < mic_pkg::IDX_DIGITS) ? MAX_LEN : mic_pkg::IDX_DIGITS;
  localparam int IW      = mic_pkg::IDX_W;

  logic [IW-1:0] acc_r, acc_nxt;
  logic [IW-1:0] off_r, off_nxt;
  logic [CW-1:0] chars_r, chars_nxt;
  logic          long_r, long_nxt;

  logic                           take;
  logic                           has_room;
  logic [mic_pkg::DIG_W-1:0]      digit;
  logic [IW-1:0]                  acc_ins, off_ins, enc_index;
  logic [IW-1:0]                  acc_n, off_n;
  logic [CW-1:0]                  chars_n;
  logic                           long_n;
  logic [mic_pkg::LEN_W-1:0]      dec_len;
  logic [IW-1:0]                  dec_base;
  logic [IW-1:0]                  dec_rem;
  mic_pkg::mic_entry_t            enc_entry, dec_entry;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  // encode: absorb one character (x5 as shift and add)
  always_comb begin
    has_room = chars_r < CW'(MAX_LEN);
    digit    = mic_pkg::digit_of(in_ch.char_in);
    acc_ins  = IW'({acc_r, 2'b00} + {2'b00, acc_r} + (IW + 2)'(digit));
    off_ins  = (chars_r != '0) ? IW'({off_r, 2'b00} + {2'b00, off_r} + (IW + 2)'(5)) : off_r;
    acc_n    = has_room ? acc_ins : acc_r;
    off_n    = has_room ? off_ins : off_r;
    chars_n  = has_room ? chars_r + CW'(1) : chars_r;
    long_n   = long_r || !has_room;
    enc_index = acc_n + off_n;

    enc_entry.kind = mic_pkg::KIND_SINGLE;
    if (long_n) begin
      enc_entry.value  = '0;
      enc_entry.len    = mic_pkg::LEN_W'(MAX_LEN);
      enc_entry.status = mic_pkg::ST_TOO_LONG;
    end else begin
      enc_entry.value  = enc_index;
      enc_entry.len    = mic_pkg::LEN_W'(chars_n);
      enc_entry.status = mic_pkg::ST_OK;
    end
  end

  // decode: length search against constant bounds, smallest match wins
  always_comb begin
    dec_len  = '0;
    dec_base = '0;
    for (int l = DEC_MAX; l >= 1; l--) begin
      if ({{(64 - IW){1'b0}}, in_ch.index_in} < mic_pkg::cum_off(l + 1)) begin
        dec_len  = mic_pkg::LEN_W'(l);
        dec_base = IW'(mic_pkg::cum_off(l));
      end
    end
    dec_rem = in_ch.index_in - dec_base;

    if (dec_len == '0) begin
      dec_entry.kind   = mic_pkg::KIND_SINGLE;
      dec_entry.value  = '0;
      dec_entry.len    = '0;
      dec_entry.status = mic_pkg::ST_RANGE;
    end else begin
      dec_entry.kind   = mic_pkg::KIND_DIGITS;
      dec_entry.value  = dec_rem;
      dec_entry.len    = dec_len;
      dec_entry.status = mic_pkg::ST_OK;
    end
  end

  always_comb begin
    acc_nxt   = acc_r;
    off_nxt   = off_r;
    chars_nxt = chars_r;
    long_nxt  = long_r;
    q_push    = 1'b0;
    q_entry   = dec_entry;
    if (take) begin
      if (mic_pkg::mic_cmd_t'(in_ch.command) == mic_pkg::CMD_DECODE) begin
        q_push = 1'b1;
      end else if (in_ch.char_is_last) begin
        q_push    = 1'b1;
        q_entry   = enc_entry;
        acc_nxt   = '0;
        off_nxt   = '0;
        chars_nxt = '0;
        long_nxt  = 1'b0;
      end else begin
        acc_nxt   = acc_n;
        off_nxt   = off_n;
        chars_nxt = chars_n;
        long_nxt  = long_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      off_r   <= '0;
      chars_r <= '0;
      long_r  <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      off_r   <= off_nxt;
      chars_r <= chars_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

// ===== hw/rtl/mic_fifo.sv =====
module mic_fifo #(
  parameter int DEPTH = mic_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mic_pkg::mic_entry_t wr_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output mic_pkg::mic_entry_t rd_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  mic_pkg::mic_entry_t mem_r [DEPTH];
  logic [PW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;

  assign full      = cnt_r == NW'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign rd_entry  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/mic_back.sv =====
module mic_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  mic_pkg::mic_entry_t q_entry,
  output logic                q_pop,
  mic_out_if.source           out_ch
);

  localparam int IW = mic_pkg::IDX_W;
  localparam int LW = mic_pkg::LEN_W;
  localparam int TW = mic_pkg::THR_W;

  logic                 busy_r, busy_nxt;
  mic_pkg::mic_kind_t   kind_r;
  logic [IW-1:0]        val_r;
  logic [LW-1:0]        len_r;
  logic [LW-1:0]        k_r;
  mic_pkg::mic_status_t status_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [IW-1:0]              index_out_r;
  logic [mic_pkg::CHAR_W-1:0] char_out_r;
  logic [LW-1:0]              len_out_r;
  logic                       last_out_r;
  mic_pkg::mic_status_t       st_out_r;

  logic                       load_ok, emit, done;
  logic [TW-1:0]              thr [5];
  logic [mic_pkg::DIG_W-1:0]  dig;

  assign load_ok = !out_valid_r || out_ch.ready;
  assign emit    = busy_r && load_ok;
  assign done    = (kind_r == mic_pkg::KIND_SINGLE) || (k_r == '0);
  assign q_pop   = !busy_r && q_not_empty;

  // d * 5^k for the current digit place, constants per place
  always_comb begin
    for (int d = 0; d < 5; d++) begin
      thr[d] = '0;
    end
    for (int j = 0; j < mic_pkg::IDX_DIGITS; j++) begin
      if (k_r == LW'(j)) begin
        for (int d = 1; d < 5; d++) begin
          thr[d] = TW'(mic_pkg::pow5(j) * 64'(d));
        end
      end
    end
    dig = '0;
    for (int d = 1; d < 5; d++) begin
      if ({{(TW - IW){1'b0}}, val_r} >= thr[d]) begin
        dig = mic_pkg::DIG_W'(d);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
    end else if (emit && done) begin
      busy_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_entry.kind;
      val_r    <= q_entry.value;
      len_r    <= q_entry.len;
      k_r      <= q_entry.len - LW'(1);
      status_r <= q_entry.status;
    end else if (emit && kind_r == mic_pkg::KIND_DIGITS) begin
      val_r <= val_r - IW'(thr[dig]);
      k_r   <= k_r - LW'(1);
    end
    if (emit) begin
      len_out_r  <= len_r;
      last_out_r <= done;
      st_out_r   <= status_r;
      if (kind_r == mic_pkg::KIND_DIGITS) begin
        index_out_r <= '0;
        char_out_r  <= mic_pkg::char_of(dig);
      end else begin
        index_out_r <= val_r;
        char_out_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.index_out    = index_out_r;
  assign out_ch.char_out     = char_out_r;
  assign out_ch.motif_length = len_out_r;
  assign out_ch.run_last     = last_out_r;
  assign out_ch.status       = st_out_r;

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> busy_r)
    else $error("pop did not start work");

  a_digit_place: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && kind_r == mic_pkg::KIND_DIGITS |-> k_r < len_r)
    else $error("digit place beyond motif length");

  a_range_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_out_r == mic_pkg::ST_RANGE
      |-> len_out_r == '0 && last_out_r && index_out_r == '0 && char_out_r == '0)
    else $error("bad out-of-range result");

  a_char_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && char_out_r != '0 |-> st_out_r == mic_pkg::ST_OK && index_out_r == '0)
    else $error("character result with status or index");

endmodule

// ===== hw/rtl/motif_index_codec.sv =====
// Motif index codec: converts between DNA motifs (A,C,G,T,N; length 1 to
// MAX_LEN) and a flat index = base-5 value of the motif (first character most
// significant) + count of all shorter motifs. Encode (command 0) takes one
// character per transfer, any other byte counting as A; the character marked
// char_is_last yields one result with index_out and motif_length, or status 1
// if more than MAX_LEN characters came. Decode (command 1) takes an index and
// yields one result per character, first to last, run_last on the final one;
// an index at or above the total count of motifs yields one result with
// status 2, run_last set and all other fields zero. Decode transfers do not
// disturb a motif being encoded. Rate: encode characters are taken one per
// cycle while the queue is not full. Each queued job (encode result or decode
// index) is loaded into the back end, which takes no new job until it has
// issued its last result; its digit extractor makes one base-5 digit per cycle
// unless the output stalls. A small queue lets the front keep taking input.
module motif_index_codec #(
  parameter int MAX_LEN    = mic_pkg::MAX_LEN_DEF,  // 1..8
  parameter int FIFO_DEPTH = mic_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  mic_in_if.sink     in_ch,
  mic_out_if.source  out_ch
);

  // front -> queue -> back
  logic                q_push, q_pop, q_full, q_not_empty;
  mic_pkg::mic_entry_t q_wr, q_rd;

  // front: takes every transfer, runs the encode accumulator and the
  // decode length search, queues one job per result group
  mic_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr)
  );

  mic_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (q_wr),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rd_entry  (q_rd)
  );

  // back: emits results through a registered output stage
  mic_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_entry     (q_rd),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
